// File: rtl/core/first_fit_heap_allocator_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit heap allocator core
// Shared forms for clocked checks that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_MACROS_SVH

// Check that a condition holds in every cycle out of reset.
`define FFH_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define FFH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and codes shared by the heap allocator core and its table cells.
// ----------------------------------------------------------------------------
package ffha_pkg;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOSPACE  = 2'd1,
        ST_NOTALLOC = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    // Commands broadcast to every free-table cell.
    typedef enum logic [2:0] {
        FC_HOLD,
        FC_LOAD,    // load the selected cell with the given segment
        FC_SETLEN,  // overwrite the length of the selected cell
        FC_SETBOTH, // overwrite start and length of the selected cell
        FC_SHL,     // cells at or above index take their upper neighbor
        FC_SHR      // cells above index take their lower neighbor, the cell at index loads the segment
    } t_fcmd;

    typedef struct packed {
        t_fcmd       cmd;
        logic [8:0]  idx;
        logic [31:0] start;
        logic [31:0] len;
    } t_fctl;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BUILD,
        S_DISPATCH,
        S_ASCAN,
        S_USCAN,
        S_ACOMMIT,
        S_FSCAN,
        S_FPOS,
        S_FMERGE,
        S_SHIFT,
        S_OUT
    } t_state;

endpackage

// File: rtl/core/ffha_free_cell.sv
// ----------------------------------------------------------------------------
// ffha_free_cell
// One free-table entry; loads, edits or takes a neighbor's entry on command.
// ----------------------------------------------------------------------------
module ffha_free_cell
    import ffha_pkg::*;
#(
    parameter int IDX_W = 4,
    parameter int MY_IDX = 0
) (
    input  logic        i_clk,
    input  t_fctl       i_ctl,
    input  logic [31:0] i_up_start,
    input  logic [31:0] i_up_len,
    input  logic [31:0] i_dn_start,
    input  logic [31:0] i_dn_len,
    output logic [31:0] o_start,
    output logic [31:0] o_len
);
    logic [31:0] r_start, n_start;
    logic [31:0] r_len, n_len;
    logic [8:0]  w_me;

    assign w_me = 9'(MY_IDX);

    always_comb begin
        n_start = r_start;
        n_len   = r_len;
        case (i_ctl.cmd)
            FC_LOAD, FC_SETBOTH: begin
                if (i_ctl.idx == w_me) begin
                    n_start = i_ctl.start;
                    n_len   = i_ctl.len;
                end
            end
            FC_SETLEN: begin
                if (i_ctl.idx == w_me) n_len = i_ctl.len;
            end
            FC_SHL: begin
                if (w_me >= i_ctl.idx) begin
                    n_start = i_up_start;
                    n_len   = i_up_len;
                end
            end
            FC_SHR: begin
                if (w_me > i_ctl.idx) begin
                    n_start = i_dn_start;
                    n_len   = i_dn_len;
                end else if (w_me == i_ctl.idx) begin
                    n_start = i_ctl.start;
                    n_len   = i_ctl.len;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_len   <= n_len;
    end

    assign o_start = r_start;
    assign o_len   = r_len;
endmodule

// File: rtl/core/first_fit_heap_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit allocator over an address-sorted chain of free-segment cells.
// ----------------------------------------------------------------------------
// For a request (allocate or free), the controller walks the free-table
// cells one per cycle to find the first fit or insert point, walks the used
// table (a memory, one read per cycle) for a free slot or a matching
// address, and then edits the chain, where every cell takes its neighbor's
// entry in a single shift. The first request after reset also builds the
// heap from heap_base / heap_end in the S_BUILD state; later register
// writes have no effect until reset. One request is in flight at a time;
// the result sits in an output register and the next transfer is taken
// once it has left.
// ----------------------------------------------------------------------------
`include "first_fit_heap_allocator_core_macros.svh"

module first_fit_heap_allocator_core
    import ffha_pkg::*;
#(
    parameter int FREE_SEGMENTS = 16,
    parameter int USED_BLOCKS   = 32,
    parameter int ALIGN_BYTES   = 8,
    parameter int HEADER_BYTES  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [31:0] i_request_size,
    input  logic [31:0] i_block_address,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_user_address,
    output logic [31:0] o_remaining_bytes,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int FI_W = (FREE_SEGMENTS > 1) ? $clog2(FREE_SEGMENTS) : 1;
    localparam int FC_W = $clog2(FREE_SEGMENTS + 1);
    localparam int UI_W = (USED_BLOCKS > 1) ? $clog2(USED_BLOCKS) : 1;
    localparam int UC_W = $clog2(USED_BLOCKS + 1);
    localparam int AL_W = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1;
    localparam logic [33:0] HDR = 34'(HEADER_BYTES);
    localparam logic [33:0] ALN = 34'(ALIGN_BYTES);

    // ---------------- configuration registers --------------------------------
    logic [31:0] r_base, r_end;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= 32'd0;
            r_end  <= 32'd1048576;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == 1'b0) r_base <= i_cfg_data;
            else                     r_end  <= i_cfg_data;
        end
    end

    // ---------------- free-segment cell chain --------------------------------
    t_fctl       w_fctl;
    logic [31:0] w_fs [FREE_SEGMENTS+1];
    logic [31:0] w_fl [FREE_SEGMENTS+1];
    assign w_fs[FREE_SEGMENTS] = 32'd0;
    assign w_fl[FREE_SEGMENTS] = 32'd0;

    for (genvar g = 0; g < FREE_SEGMENTS; g++) begin : g_cell
        ffha_free_cell #(.IDX_W(FI_W), .MY_IDX(g)) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_fctl),
            .i_up_start (w_fs[g+1]),
            .i_up_len   (w_fl[g+1]),
            .i_dn_start ((g == 0) ? 32'd0 : w_fs[(g == 0) ? 0 : g-1]),
            .i_dn_len   ((g == 0) ? 32'd0 : w_fl[(g == 0) ? 0 : g-1]),
            .o_start    (w_fs[g]),
            .o_len      (w_fl[g])
        );
    end

    // ---------------- used table (memory) ------------------------------------
    logic [31:0] m_ustart [USED_BLOCKS];
    logic [31:0] m_ulen   [USED_BLOCKS];
    logic [USED_BLOCKS-1:0] r_uvalid;
    logic [31:0] r_us_rd, r_ul_rd;
    logic        u_we;
    logic [UI_W-1:0] u_waddr, u_raddr;
    logic [31:0] u_wstart, u_wlen;

    always_ff @(posedge i_clk) begin
        if (u_we) begin
            m_ustart[u_waddr] <= u_wstart;
            m_ulen[u_waddr]   <= u_wlen;
        end
        r_us_rd <= m_ustart[u_raddr];
        r_ul_rd <= m_ulen[u_raddr];
    end

    // ---------------- controller ---------------------------------------------
    t_state r_state, n_state;
    logic [FC_W-1:0] r_fcnt, n_fcnt;
    logic [31:0]     r_left, n_left;
    logic            r_ready, n_ready;
    logic [USED_BLOCKS-1:0] n_uvalid;
    logic            r_op, n_op;
    logic [33:0]     r_need, n_need;
    logic [31:0]     r_addr, n_addr;
    logic [31:0]     r_raw;          // raw request size, kept for the bytes_left check
    logic [FC_W-1:0] r_fi, n_fi;     // free-table walk index
    logic [UC_W-1:0] r_ui, n_ui;     // used-table walk index
    logic            r_rdv, n_rdv;   // read data of previous index is valid
    logic [UI_W-1:0] r_uhit, n_uhit;
    logic [31:0]     r_s, n_s, r_l, n_l;
    logic [31:0]     r_ps, n_ps, r_pl, n_pl; // predecessor cell
    logic            r_ov, n_ov;
    logic [1:0]      r_ost, n_ost;
    logic [31:0]     r_oaddr, n_oaddr, r_orem, n_orem;

    logic [FI_W-1:0] w_fsel;
    logic [33:0]     w_sum, w_rnd;
    logic [AL_W-1:0] w_rem;
    logic [33:0]     w_e, w_b;
    logic [UI_W-1:0] w_ulast;

    assign w_fsel  = r_fi[FI_W-1:0];
    assign w_ulast = r_ui[UI_W-1:0] - 1'b1;
    assign u_raddr = r_ui[UI_W-1:0];

    always_comb begin
        w_sum = {2'b0, i_request_size} + HDR;
        if (ALIGN_BYTES > 1) w_rem = w_sum[AL_W-1:0];
        else                 w_rem = '0;
        w_rnd = (w_rem != '0) ? (w_sum + ALN - 34'(w_rem)) : w_sum;
        w_b = {2'b0, r_base};
        w_e = {2'b0, r_end};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fcnt   <= '0;
            r_left   <= '0;
            r_ready  <= 1'b0;
            r_uvalid <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fcnt   <= n_fcnt;
            r_left   <= n_left;
            r_ready  <= n_ready;
            r_uvalid <= n_uvalid;
            r_ov     <= n_ov;
        end
        r_op <= n_op;   r_need <= n_need; r_addr <= n_addr;
        r_fi <= n_fi;   r_ui <= n_ui;     r_rdv <= n_rdv;   r_uhit <= n_uhit;
        r_s <= n_s;     r_l <= n_l;       r_ps <= n_ps;     r_pl <= n_pl;
        r_ost <= n_ost; r_oaddr <= n_oaddr; r_orem <= n_orem;
    end

    assign o_stall = (r_state != S_IDLE) || r_ov;

    always_comb begin
        logic [31:0] cs, cl;
        logic [33:0] tmp;
        logic        mp, mn;
        n_state = r_state; n_fcnt = r_fcnt; n_left = r_left; n_ready = r_ready;
        n_uvalid = r_uvalid; n_op = r_op; n_need = r_need; n_addr = r_addr;
        n_fi = r_fi; n_ui = r_ui; n_rdv = 1'b0; n_uhit = r_uhit;
        n_s = r_s; n_l = r_l; n_ps = r_ps; n_pl = r_pl;
        n_ov = r_ov; n_ost = r_ost; n_oaddr = r_oaddr; n_orem = r_orem;
        w_fctl = '{cmd: FC_HOLD, idx: 9'(r_fi), start: 32'd0, len: 32'd0};
        u_we = 1'b0; u_waddr = r_uhit; u_wstart = r_s; u_wlen = r_l;
        cs = w_fs[w_fsel]; cl = w_fl[w_fsel];
        tmp = '0; mp = 1'b0; mn = 1'b0;
        if (r_ov && !i_stall) n_ov = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid && !o_stall) begin
                    n_op = i_operation; n_need = w_rnd; n_addr = i_block_address;
                    n_state = r_ready ? S_DISPATCH : S_BUILD;
                end
            end
            S_BUILD: begin
                n_ready = 1'b1; n_fcnt = '0; n_left = '0;
                if (w_e >= w_b + HDR && (w_e - HDR - w_b) != 34'd0) begin
                    tmp = w_e - HDR - w_b;
                    w_fctl = '{cmd: FC_LOAD, idx: 9'd0, start: r_base, len: tmp[31:0]};
                    n_fcnt = FC_W'(1); n_left = tmp[31:0];
                end
                n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                n_fi = '0; n_ui = '0;
                if (r_op == OP_ALLOC) begin
                    // oversized requests fail before any table walk
                    if (r_left < r_raw) begin
                        n_ost = ST_NOSPACE; n_oaddr = '0; n_state = S_OUT;
                    end else begin
                        n_state = S_ASCAN;
                    end
                end else if (r_addr == 32'd0) begin
                    n_ost = ST_OK; n_oaddr = '0; n_state = S_OUT;
                end else begin
                    n_state = S_USCAN;
                end
            end
            S_ASCAN: begin
                if (r_fi >= r_fcnt) begin
                    n_ost = ST_NOSPACE; n_oaddr = '0; n_state = S_OUT;
                end else if ({2'b0, cl} >= r_need) begin
                    n_s = cs; n_l = cl; n_state = S_USCAN;
                end else begin
                    n_fi = r_fi + 1'b1;
                end
            end
            S_USCAN: begin
                if (r_op == OP_ALLOC) begin
                    if (r_ui >= UC_W'(USED_BLOCKS)) begin
                        n_ost = ST_FULL; n_oaddr = '0; n_state = S_OUT;
                    end else if (!r_uvalid[u_raddr]) begin
                        n_uhit = u_raddr; n_state = S_ACOMMIT;
                    end else begin
                        n_ui = r_ui + 1'b1;
                    end
                end else begin
                    n_rdv = (r_ui < UC_W'(USED_BLOCKS));
                    if (r_rdv && r_uvalid[w_ulast]
                            && {2'b0, r_us_rd} + HDR == {2'b0, r_addr}) begin
                        n_uhit = w_ulast; n_s = r_us_rd; n_l = r_ul_rd;
                        n_fi = '0; n_rdv = 1'b0; n_state = S_FSCAN;
                    end else if (r_ui >= UC_W'(USED_BLOCKS)) begin
                        n_ost = ST_NOTALLOC; n_oaddr = '0; n_state = S_OUT;
                    end else begin
                        n_ui = r_ui + 1'b1;
                    end
                end
            end
            S_ACOMMIT: begin
                tmp = {2'b0, r_l} - r_need;
                if (tmp > HDR) begin
                    w_fctl = '{cmd: FC_SETBOTH, idx: 9'(r_fi),
                               start: 32'({2'b0, r_s} + r_need), len: tmp[31:0]};
                    n_l = r_need[31:0];
                end else begin
                    w_fctl = '{cmd: FC_SHL, idx: 9'(r_fi), start: 32'd0, len: 32'd0};
                    n_fcnt = r_fcnt - 1'b1;
                end
                u_we = 1'b1; u_waddr = r_uhit; u_wstart = r_s;
                u_wlen = (tmp > HDR) ? r_need[31:0] : r_l;
                n_uvalid[r_uhit] = 1'b1;
                n_left = r_left - u_wlen;
                n_ost = ST_OK; n_oaddr = r_s + 32'(HEADER_BYTES);
                n_state = S_OUT;
            end
            S_FSCAN: begin
                if (r_fi >= r_fcnt || cs > r_s) begin
                    n_state = S_FMERGE;
                end else begin
                    n_ps = cs; n_pl = cl; n_fi = r_fi + 1'b1;
                end
            end
            S_FMERGE: begin
                mp = (r_fi != '0) && ({2'b0, r_ps} + {2'b0, r_pl} == {2'b0, r_s});
                mn = (r_fi < r_fcnt) && ({2'b0, r_s} + {2'b0, r_l} == {2'b0, cs});
                n_ost = ST_OK; n_oaddr = '0; n_state = S_OUT;
                if (mp) begin
                    w_fctl = '{cmd: FC_SETLEN, idx: 9'(r_fi - 1'b1), start: 32'd0,
                               len: r_pl + r_l + (mn ? cl : 32'd0)};
                    if (mn) begin
                        n_state = S_SHIFT;
                    end
                end else if (mn) begin
                    w_fctl = '{cmd: FC_SETBOTH, idx: 9'(r_fi), start: r_s, len: cl + r_l};
                end else if (r_fcnt >= FC_W'(FREE_SEGMENTS)) begin
                    n_ost = ST_FULL;
                end else begin
                    w_fctl = '{cmd: FC_SHR, idx: 9'(r_fi), start: r_s, len: r_l};
                    n_fcnt = r_fcnt + 1'b1;
                end
                if (n_ost == ST_OK) begin
                    n_uvalid[r_uhit] = 1'b0;
                    n_left = r_left + r_l;
                end
            end
            S_SHIFT: begin
                w_fctl = '{cmd: FC_SHL, idx: 9'(r_fi), start: 32'd0, len: 32'd0};
                n_fcnt = r_fcnt - 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                n_orem = r_left;
                if (!n_ov) begin
                    n_ov = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid && !o_stall) r_raw <= i_request_size;
    end

    assign o_valid           = r_ov;
    assign o_status          = r_ost;
    assign o_user_address    = r_oaddr;
    assign o_remaining_bytes = r_orem;

    `FFH_ASSERT_ALWAYS(a_fcnt_range, i_clk, i_rst_n, r_fcnt <= FC_W'(FREE_SEGMENTS), "free count overflow")
    `FFH_ASSERT_NEXT(a_one_result, i_clk, i_rst_n, r_ov && !i_stall, !r_ov, "result repeated")
    `FFH_ASSERT_ALWAYS(a_busy_stall, i_clk, i_rst_n, (r_state == S_IDLE) || o_stall, "input taken while busy")
    `FFH_ASSERT_NEXT(a_fail_noaddr, i_clk, i_rst_n, r_state == S_OUT && r_ost != ST_OK, r_oaddr == 32'd0, "failed request returned address")
endmodule
